// ----- rtl/core/cartridge_bank_mapper_core_assert.svh -----
// Assertion macros shared by the bank mapper modules.
// Each expects clk and rst in scope; checks are off while rst is high.
`ifndef CARTRIDGE_BANK_MAPPER_CORE_ASSERT_SVH
`define CARTRIDGE_BANK_MAPPER_CORE_ASSERT_SVH

// Same-cycle implication.
`define CBM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CBM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/cbm_pkg.sv -----
package cbm_pkg;

  localparam int ROM_BANK_BYTES = 16384;
  localparam int RAM_BANK_BYTES = 8192;
  localparam int MAX_ROM_BANKS  = 128;

  localparam int ADDR_W       = 16;
  localparam int DATA_W       = 8;
  localparam int PHYS_W       = 21;
  localparam int ROM_BANK_W   = $clog2(MAX_ROM_BANKS);
  localparam int RAM_BANK_W   = 2;
  localparam int ROM_OFFSET_W = $clog2(ROM_BANK_BYTES);
  localparam int RAM_OFFSET_W = $clog2(RAM_BANK_BYTES);
  localparam int ROM_COUNT_W  = 8;
  localparam int RAM_COUNT_W  = 3;
  localparam int CFG_INDEX_W  = 8;
  localparam int CFG_DATA_W   = 8;

  localparam logic [3:0]       RAM_ENABLE_KEY     = 4'hA;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROM_BANK_COUNT = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_RAM_BANK_COUNT = 8'd1;

  typedef enum logic [0:0] {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    TGT_ROM  = 2'd0,
    TGT_RAM  = 2'd1,
    TGT_OPEN = 2'd2,
    TGT_REG  = 2'd3
  } target_t;

  // Address bits 15..13 select an 8 KiB region of the CPU map.
  typedef enum logic [2:0] {
    REGION_RAM_EN   = 3'd0,
    REGION_ROM_LO   = 3'd1,
    REGION_ROM_HI   = 3'd2,
    REGION_MODE     = 3'd3,
    REGION_VIDEO    = 3'd4,
    REGION_CART_RAM = 3'd5,
    REGION_WORK     = 3'd6,
    REGION_HIGH     = 3'd7
  } region_t;

  typedef struct packed {
    opcode_t           opcode;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] write_data;
  } item_t;

  typedef struct packed {
    target_t           target;
    logic [PHYS_W-1:0] phys_addr;
    logic              ram_write;
  } result_t;

  typedef struct packed {
    logic [ROM_BANK_W-1:0] rom_mask;
    logic [RAM_BANK_W-1:0] ram_mask;
  } bank_masks_t;

endpackage

// ----- rtl/core/cbm_cfg.sv -----
module cbm_cfg
  import cbm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output bank_masks_t            masks
);

  logic [ROM_COUNT_W-1:0] rom_count;
  logic [RAM_COUNT_W-1:0] ram_count;
  logic [ROM_COUNT_W-1:0] rom_count_m1;
  logic [RAM_COUNT_W-1:0] ram_count_m1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rom_count <= ROM_COUNT_W'(2);
      ram_count <= RAM_COUNT_W'(1);
    end else if (cfg_valid) begin
      if (cfg_index == CFG_ROM_BANK_COUNT) begin
        rom_count <= cfg_data[ROM_COUNT_W-1:0];
      end else if (cfg_index == CFG_RAM_BANK_COUNT) begin
        ram_count <= cfg_data[RAM_COUNT_W-1:0];
      end
    end
  end

  // A count of zero wraps to an all-ones mask, clipped to the bank width.
  assign rom_count_m1 = rom_count - ROM_COUNT_W'(1);
  assign ram_count_m1 = ram_count - RAM_COUNT_W'(1);

  assign masks.rom_mask = rom_count_m1[ROM_BANK_W-1:0];
  assign masks.ram_mask = ram_count_m1[RAM_BANK_W-1:0];

endmodule

// ----- rtl/core/cbm_in_stage.sv -----
module cbm_in_stage
  import cbm_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  item_t in_item,
  input  logic  down_free,
  output logic  fire,
  output item_t item
);

  logic held;

  assign in_stall = held && !down_free;
  assign fire     = held && down_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (!in_stall) begin
      held <= in_valid;
    end
  end

  // Load a new word when the register is empty or the held one moves on.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item <= in_item;
    end
  end

endmodule

// ----- rtl/core/cbm_map.sv -----
module cbm_map
  import cbm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        fire,
  input  item_t       item,
  input  bank_masks_t masks,
  output result_t     result
);

  `include "cartridge_bank_mapper_core_assert.svh"

  logic                  ram_enable;
  logic                  bank_mode;
  logic [ROM_BANK_W-1:0] rom_bank;
  logic [RAM_BANK_W-1:0] ram_bank;

  logic                  ram_enable_next;
  logic                  bank_mode_next;
  logic [ROM_BANK_W-1:0] rom_bank_next;
  logic [RAM_BANK_W-1:0] ram_bank_next;

  region_t               region;
  logic [ROM_BANK_W-1:0] rom_cand;
  logic [ROM_BANK_W-1:0] rom_reduced;
  logic [RAM_BANK_W-1:0] ram_base;
  logic [PHYS_W-1:0]     ram_phys;

  assign region = region_t'(item.addr[ADDR_W-1:ADDR_W-3]);

  // Mode one keeps RAM on bank zero.
  assign ram_base = bank_mode ? RAM_BANK_W'(0) : ram_bank;
  assign ram_phys = PHYS_W'({ram_base, item.addr[RAM_OFFSET_W-1:0]});

  always_comb begin
    if (region == REGION_ROM_HI) begin
      rom_cand = {item.write_data[1:0], rom_bank[4:0]};
    end else begin
      rom_cand = {rom_bank[ROM_BANK_W-1:5], item.write_data[4:0]};
    end
    rom_reduced = rom_cand & masks.rom_mask;
    // Banks with zero low bits step to the next bank.
    if (rom_reduced[4:0] == 5'd0) begin
      rom_reduced[0] = 1'b1;
    end
  end

  always_comb begin
    ram_enable_next  = ram_enable;
    bank_mode_next   = bank_mode;
    rom_bank_next    = rom_bank;
    ram_bank_next    = ram_bank;
    result.target    = TGT_OPEN;
    result.phys_addr = '0;
    result.ram_write = 1'b0;
    if (item.opcode == OP_READ) begin
      unique case (region) inside
        REGION_RAM_EN, REGION_ROM_LO: begin
          result.target    = TGT_ROM;
          result.phys_addr = PHYS_W'(item.addr[ROM_OFFSET_W-1:0]);
        end
        REGION_ROM_HI, REGION_MODE: begin
          result.target    = TGT_ROM;
          result.phys_addr = PHYS_W'({rom_bank, item.addr[ROM_OFFSET_W-1:0]});
        end
        REGION_CART_RAM: begin
          if (ram_enable) begin
            result.target    = TGT_RAM;
            result.phys_addr = ram_phys;
          end
        end
        default: begin
          result.target = TGT_OPEN;
        end
      endcase
    end else begin
      result.target = TGT_REG;
      unique case (region)
        REGION_RAM_EN: begin
          ram_enable_next = (item.write_data[3:0] == RAM_ENABLE_KEY);
        end
        REGION_ROM_LO: begin
          rom_bank_next = rom_reduced;
        end
        REGION_ROM_HI: begin
          if (bank_mode) begin
            rom_bank_next = rom_reduced;
          end else begin
            ram_bank_next = item.write_data[RAM_BANK_W-1:0] & masks.ram_mask;
          end
        end
        REGION_MODE: begin
          bank_mode_next = item.write_data[0];
        end
        REGION_CART_RAM: begin
          if (ram_enable) begin
            result.target    = TGT_RAM;
            result.phys_addr = ram_phys;
            result.ram_write = 1'b1;
          end
        end
        default: begin
          result.target = TGT_REG;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ram_enable <= 1'b0;
      bank_mode  <= 1'b0;
      rom_bank   <= ROM_BANK_W'(1);
      ram_bank   <= '0;
    end else if (fire) begin
      ram_enable <= ram_enable_next;
      bank_mode  <= bank_mode_next;
      rom_bank   <= rom_bank_next;
      ram_bank   <= ram_bank_next;
    end
  end

  `CBM_ASSERT_IMP(a_rom_bank_remapped, 1'b1, rom_bank[4:0] != 5'd0, "ROM bank left on a zero bank")
  `CBM_ASSERT_IMP(a_strobe_is_ram, result.ram_write, result.target == TGT_RAM, "RAM strobe off RAM")
  `CBM_ASSERT_IMP(a_ram_needs_enable, result.target == TGT_RAM, ram_enable, "RAM hit while disabled")
  `CBM_ASSERT_NXT(a_idle_holds_bank, !fire, $stable(rom_bank) && $stable(ram_bank), "bank moved idle")

endmodule

// ----- rtl/core/cbm_out_stage.sv -----
module cbm_out_stage
  import cbm_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t load_result,
  output logic    free,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t result
);

  assign free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= load;
    end
  end

  // Hold the word while the receiver stalls.
  always_ff @(posedge clk) begin
    if (load && free) begin
      result <= load_result;
    end
  end

endmodule

// ----- rtl/core/cartridge_bank_mapper_core.sv -----
// Cartridge bank mapper.
// Input channel (in_valid / in_stall): one bus access per word, with opcode
// (read or write), addr and write_data. Output channel (out_valid /
// out_stall): one word per access with target, phys_addr and ram_write.
// A word is taken on a clock edge with valid high and stall low.
// Config channel (cfg_valid / cfg_ready): index 0 sets the ROM bank count,
// index 1 the RAM bank count; other indexes are dropped. cfg_ready is
// always high; write only while no access is in flight.
// An access passes an input register, then the decode and bank register
// update, then the result register. One access is taken every cycle while
// out_stall is low; bank register writes take effect for the very next
// access. When out_stall is high the result holds, one more access waits in
// the input register, and in_stall rises only once both are full.
// Synchronous reset (rst) empties both registers, disables RAM, selects
// mode zero, ROM bank 1, RAM bank 0, and counts of 2 ROM and 1 RAM bank.
module cartridge_bank_mapper_core
  import cbm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   opcode,
  input  logic [ADDR_W-1:0]      addr,
  input  logic [DATA_W-1:0]      write_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             target,
  output logic [PHYS_W-1:0]      phys_addr,
  output logic                   ram_write,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  `include "cartridge_bank_mapper_core_assert.svh"

  item_t       in_item;
  item_t       item;
  bank_masks_t masks;
  result_t     map_result;
  result_t     out_result;
  logic        fire;
  logic        down_free;

  assign cfg_ready = 1'b1;

  assign in_item.opcode     = opcode_t'(opcode);
  assign in_item.addr       = addr;
  assign in_item.write_data = write_data;

  cbm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .masks     (masks)
  );

  cbm_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .down_free (down_free),
    .fire      (fire),
    .item      (item)
  );

  cbm_map u_map (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (item),
    .masks  (masks),
    .result (map_result)
  );

  cbm_out_stage u_out (
    .clk         (clk),
    .rst         (rst),
    .load        (fire),
    .load_result (map_result),
    .free        (down_free),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result      (out_result)
  );

  assign target    = out_result.target;
  assign phys_addr = out_result.phys_addr;
  assign ram_write = out_result.ram_write;

  `CBM_ASSERT_IMP(a_stall_only_when_full, in_stall, out_valid && out_stall, "input stalled early")
  `CBM_ASSERT_NXT(a_fire_fills_output, fire, out_valid, "accepted access lost")

endmodule

// ----- sim/cartridge_bank_mapper_checker.sv -----
module cartridge_bank_mapper_checker
  import cbm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  logic                   opcode,
  input  logic [ADDR_W-1:0]      addr,
  input  logic [DATA_W-1:0]      write_data,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  logic [1:0]             target,
  input  logic [PHYS_W-1:0]      phys_addr,
  input  logic                   ram_write,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     mismatches,
  output int                     outstanding
);

  logic [ROM_COUNT_W-1:0] rom_count;
  logic [RAM_COUNT_W-1:0] ram_count;
  logic                   ram_on;
  logic                   mode_one;
  logic [ROM_BANK_W-1:0]  rom_sel;
  logic [RAM_BANK_W-1:0]  ram_sel;

  result_t awaited_maps[$];
  item_t   access_word;
  result_t want;
  result_t got;
  int      pushed;
  int      popped;

  function automatic logic [ROM_BANK_W-1:0] fold_rom_bank(input logic [ROM_BANK_W-1:0] bank);
    logic [ROM_COUNT_W-1:0] span;
    logic [ROM_BANK_W-1:0]  b;
    span = rom_count - 1'b1;
    b = bank & span[ROM_BANK_W-1:0];
    // banks 0x00, 0x20, 0x40, 0x60 step on to the next one
    if (b[4:0] == 5'd0) b = b + 1'b1;
    return b;
  endfunction

  function automatic logic [PHYS_W-1:0] cart_ram_addr(input logic [ADDR_W-1:0] a);
    // mode one pins cartridge RAM to bank 0
    if (mode_one) return PHYS_W'(a[RAM_OFFSET_W-1:0]);
    return PHYS_W'({ram_sel, a[RAM_OFFSET_W-1:0]});
  endfunction

  task automatic map_access(input item_t acc, output result_t res);
    logic [RAM_COUNT_W-1:0] ram_span;
    logic                   in_cart_ram;
    ram_span    = ram_count - 1'b1;
    in_cart_ram = (region_t'(acc.addr[15:13]) == REGION_CART_RAM);
    res.target    = TGT_REG;
    res.phys_addr = '0;
    res.ram_write = 1'b0;
    if (acc.opcode == OP_READ) begin
      if (acc.addr < 16'h4000) begin
        res.target    = TGT_ROM;
        res.phys_addr = PHYS_W'(acc.addr);
      end else if (acc.addr < 16'h8000) begin
        res.target    = TGT_ROM;
        res.phys_addr = {rom_sel, acc.addr[ROM_OFFSET_W-1:0]};
      end else if (in_cart_ram && ram_on) begin
        res.target    = TGT_RAM;
        res.phys_addr = cart_ram_addr(acc.addr);
      end else begin
        res.target = TGT_OPEN;
      end
    end else begin
      case (region_t'(acc.addr[15:13]))
        REGION_RAM_EN: ram_on = (acc.write_data[3:0] == RAM_ENABLE_KEY);
        REGION_ROM_LO: rom_sel = fold_rom_bank({rom_sel[6:5], acc.write_data[4:0]});
        REGION_ROM_HI: begin
          if (mode_one) rom_sel = fold_rom_bank({acc.write_data[1:0], rom_sel[4:0]});
          else ram_sel = acc.write_data[1:0] & ram_span[RAM_BANK_W-1:0];
        end
        REGION_MODE: mode_one = acc.write_data[0];
        REGION_CART_RAM: begin
          if (ram_on) begin
            res.target    = TGT_RAM;
            res.phys_addr = cart_ram_addr(acc.addr);
            res.ram_write = 1'b1;
          end
        end
        default: ;
      endcase
    end
  endtask

  task automatic flag_fault(input string why, input result_t exp_w, input result_t act_w);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: expected target %0d phys %06h wr %0b, got target %0d phys %06h wr %0b",
               $realtime, why, exp_w.target, exp_w.phys_addr, exp_w.ram_write,
               act_w.target, act_w.phys_addr, act_w.ram_write);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rom_count   = ROM_COUNT_W'(2);
      ram_count   = RAM_COUNT_W'(1);
      ram_on      = 1'b0;
      mode_one    = 1'b0;
      rom_sel     = ROM_BANK_W'(1);
      ram_sel     = '0;
      mismatches  = 0;
      awaited_maps.delete();
      outstanding <= 0;
    end else begin
      pushed = 0;
      popped = 0;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_ROM_BANK_COUNT) rom_count = cfg_data;
        else if (cfg_index == CFG_RAM_BANK_COUNT) ram_count = cfg_data[RAM_COUNT_W-1:0];
      end
      if (in_valid && !in_stall) begin
        access_word.opcode     = opcode_t'(opcode);
        access_word.addr       = addr;
        access_word.write_data = write_data;
        map_access(access_word, want);
        awaited_maps.push_back(want);
        pushed = 1;
      end
      if (out_valid && !out_stall) begin
        got.target    = target_t'(target);
        got.phys_addr = phys_addr;
        got.ram_write = ram_write;
        if (awaited_maps.size() == 0) begin
          want = '0;
          flag_fault("unexpected word", want, got);
        end else begin
          want   = awaited_maps.pop_front();
          popped = 1;
          if (got.target !== want.target || got.phys_addr !== want.phys_addr ||
              got.ram_write !== want.ram_write)
            flag_fault("mismatch", want, got);
        end
      end
      outstanding <= outstanding + pushed - popped;
    end
  end

endmodule

// ----- sim/cartridge_bank_mapper_core_tb.sv -----
module cartridge_bank_mapper_core_tb;
  import cbm_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 130;

  localparam logic [7:0] ROM_COUNTS [0:PHASES-1] =
    '{8'd2, 8'd128, 8'd4, 8'd0, 8'd3, 8'd64, 8'd255, 8'd16, 8'd1, 8'd32, 8'd8, 8'd128};
  localparam logic [2:0] RAM_COUNTS [0:PHASES-1] =
    '{3'd1, 3'd4, 3'd2, 3'd0, 3'd3, 3'd4, 3'd7, 3'd1, 3'd2, 3'd5, 3'd4, 3'd4};
  localparam int SEND_PCT  [0:3] = '{0, 53, 0, 32};
  localparam int STALL_PCT [0:3] = '{0, 0, 53, 32};

  logic                   clk        = 1'b0;
  logic                   rst        = 1'b1;
  logic                   in_valid   = 1'b0;
  logic                   in_stall;
  logic                   opcode     = 1'b0;
  logic [ADDR_W-1:0]      addr       = '0;
  logic [DATA_W-1:0]      write_data = '0;
  logic                   out_valid;
  logic                   out_stall  = 1'b0;
  logic [1:0]             target;
  logic [PHYS_W-1:0]      phys_addr;
  logic                   ram_write;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;

  int mismatches;
  int outstanding;
  int send_pct    = 0;
  int stall_pct   = 0;
  int cycle_count = 0;

  cartridge_bank_mapper_core dut (.*);

  cartridge_bank_mapper_checker checker_i (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= (rst || stall_pct == 0) ? 1'b0 : ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** cartridge_bank_mapper_core: FAILED **");
      $finish;
    end
  end

  task automatic send_access(input opcode_t op, input logic [ADDR_W-1:0] a,
                             input logic [DATA_W-1:0] d);
    while (send_pct != 0 && $urandom_range(0, 99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    opcode     <= op;
    addr       <= a;
    write_data <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // hold the sender until every word has come back, then let the pipe settle
  task automatic drain_bank_mapper();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_count(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_access();
    int                kind;
    opcode_t           op;
    logic [ADDR_W-1:0] a;
    logic [DATA_W-1:0] d;
    kind = $urandom_range(0, 99);
    op   = opcode_t'($urandom_range(0, 1));
    a    = ADDR_W'($urandom_range(0, 16'hFFFF));
    d    = DATA_W'($urandom_range(0, 255));
    if (kind < 15) begin
      op = OP_READ;
      a  = ADDR_W'($urandom_range(16'h0000, 16'h3FFF));
    end else if (kind < 30) begin
      op = OP_READ;
      a  = ADDR_W'($urandom_range(16'h4000, 16'h7FFF));
    end else if (kind < 50) begin
      a = ADDR_W'($urandom_range(16'hA000, 16'hBFFF));
    end else if (kind < 58) begin
      op = OP_WRITE;
      a  = ADDR_W'($urandom_range(16'h0000, 16'h1FFF));
      if ($urandom_range(0, 9) < 6) d[3:0] = RAM_ENABLE_KEY;
    end else if (kind < 68) begin
      op = OP_WRITE;
      a  = ADDR_W'($urandom_range(16'h2000, 16'h3FFF));
      // clear the low five bits now and then to hit the bank remap
      if ($urandom_range(0, 3) == 0) d[4:0] = 5'd0;
    end else if (kind < 76) begin
      op = OP_WRITE;
      a  = ADDR_W'($urandom_range(16'h4000, 16'h5FFF));
    end else if (kind < 82) begin
      op = OP_WRITE;
      a  = ADDR_W'($urandom_range(16'h6000, 16'h7FFF));
    end else if (kind < 90) begin
      a = $urandom_range(0, 1) ? ADDR_W'($urandom_range(16'h8000, 16'h9FFF))
                               : ADDR_W'($urandom_range(16'hC000, 16'hFFFF));
    end
    send_access(op, a, d);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset counts: two ROM banks, one RAM bank
    send_access(OP_READ,  16'h0000, 8'h00);
    send_access(OP_READ,  16'h3FFF, 8'hFF);
    send_access(OP_READ,  16'h7FFF, 8'h00);
    send_access(OP_READ,  16'hA000, 8'h00);
    send_access(OP_WRITE, 16'hBFFF, 8'hFF);
    send_access(OP_READ,  16'hFFFF, 8'h00);
    send_access(OP_WRITE, 16'hFFFF, 8'hFF);
    send_access(OP_WRITE, 16'h0000, 8'h0A);
    send_access(OP_WRITE, 16'h4000, 8'h03);
    send_access(OP_READ,  16'hB555, 8'h00);
    drain_bank_mapper();

    write_count(CFG_ROM_BANK_COUNT, 8'd128);
    write_count(CFG_RAM_BANK_COUNT, 8'hFC);
    write_count(8'd2, 8'hFF);
    write_count(8'hFF, 8'h00);

    send_access(OP_WRITE, 16'h2000, 8'h00);
    send_access(OP_READ,  16'h4000, 8'h00);
    send_access(OP_WRITE, 16'h3FFF, 8'h1F);
    send_access(OP_READ,  16'h7FFF, 8'h00);
    send_access(OP_WRITE, 16'h5000, 8'h02);
    send_access(OP_WRITE, 16'hA123, 8'h5A);
    send_access(OP_READ,  16'hBFFF, 8'h00);
    send_access(OP_WRITE, 16'h6000, 8'h01);
    send_access(OP_WRITE, 16'h5FFF, 8'h03);
    send_access(OP_WRITE, 16'h2000, 8'hE0);
    send_access(OP_READ,  16'h4001, 8'h00);
    send_access(OP_READ,  16'hA000, 8'h00);
    send_access(OP_WRITE, 16'h7FFF, 8'hFE);
    send_access(OP_WRITE, 16'h1FFF, 8'h00);
    send_access(OP_READ,  16'hB000, 8'h00);
    send_access(OP_READ,  16'h8000, 8'h00);
    send_access(OP_WRITE, 16'h9FFF, 8'h55);

    for (int ph = 0; ph < PHASES; ph++) begin
      drain_bank_mapper();
      write_count(CFG_ROM_BANK_COUNT, ROM_COUNTS[ph]);
      write_count(CFG_RAM_BANK_COUNT, {5'($urandom_range(0, 31)), RAM_COUNTS[ph]});
      if (ph % 3 == 1)
        write_count(8'($urandom_range(2, 255)), 8'($urandom_range(0, 255)));
      send_pct  = SEND_PCT[ph % 4];
      stall_pct = STALL_PCT[ph % 4];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2) drain_bank_mapper();
        random_access();
      end
    end
    drain_bank_mapper();

    if (mismatches == 0 && outstanding == 0) begin
      $display("** cartridge_bank_mapper_core: PASSED **");
    end else begin
      $display("** cartridge_bank_mapper_core: FAILED **");
    end
    $finish;
  end

endmodule
